### rtl/etpc_pkg.sv
// Shared types and constants for the egress TSN packet classifier.
// Holds frame header offsets, EtherType and protocol codes, verdict and class codes,
// register indexes and the frame summary record. Depends on nothing.
package etpc_pkg;

   // Counter and output widths.
   localparam int COUNT_WIDTH     = 32;
   localparam int OUT_COUNT_WIDTH = 32;

   // Depth of the summary queue between the parser and the classifier.
   localparam int QUEUE_DEPTH = 2;

   // Byte position within a frame; saturates at the top value.
   localparam int POS_WIDTH = 7;
   localparam int LEN_WIDTH = 8;
   localparam logic [POS_WIDTH-1:0] POS_MAX = 7'd127;

   // Fixed byte positions in the Ethernet and VLAN headers.
   localparam logic [POS_WIDTH-1:0] POS_OUTER_HI = 7'd12;
   localparam logic [POS_WIDTH-1:0] POS_OUTER_LO = 7'd13;
   localparam logic [POS_WIDTH-1:0] POS_VLAN_TCI = 7'd14;
   localparam logic [POS_WIDTH-1:0] POS_INNER_HI = 7'd16;
   localparam logic [POS_WIDTH-1:0] POS_INNER_LO = 7'd17;

   // Offsets relative to the start of the IPv4 header and of the UDP header.
   localparam logic [POS_WIDTH-1:0] IP_PROTO_OFFSET   = 7'd9;
   localparam logic [POS_WIDTH-1:0] UDP_DPORT_HI_OFFS = 7'd2;
   localparam logic [POS_WIDTH-1:0] UDP_DPORT_LO_OFFS = 7'd3;

   // Header lengths in bytes; the minimum IHL is in 32-bit words.
   localparam logic [LEN_WIDTH-1:0] ETH_HDR_LEN  = 8'd14;
   localparam logic [LEN_WIDTH-1:0] VLAN_L3_LEN  = 8'd18;
   localparam logic [LEN_WIDTH-1:0] IP_MIN_LEN   = 8'd20;
   localparam logic [LEN_WIDTH-1:0] UDP_HDR_LEN  = 8'd8;
   localparam logic [3:0]           IHL_MIN      = 4'd5;

   // Protocol codes.
   localparam logic [15:0] ETYPE_VLAN_Q  = 16'h8100;
   localparam logic [15:0] ETYPE_VLAN_AD = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   // Priorities that map to the higher traffic classes.
   localparam logic [7:0] PRIO_HIGH   = 8'd3;
   localparam logic [7:0] PRIO_MEDIUM = 8'd2;

   typedef enum logic [1:0] {
      VERDICT_SHORT       = 2'd0,
      VERDICT_TSN         = 2'd1,
      VERDICT_BEST_EFFORT = 2'd2,
      VERDICT_TOTAL_ONLY  = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      CLASS_HIGH   = 2'd0,
      CLASS_MEDIUM = 2'd1,
      CLASS_LOW    = 2'd2
   } traffic_class_type;

   // Configuration register indexes and reset values.
   localparam int CSR_DATA_WIDTH = 16;
   typedef enum logic {
      CSR_TSN_UDP_PORT = 1'b0,
      CSR_TSN_PRIORITY = 1'b1
   } csr_index_type;
   localparam logic [15:0] TSN_UDP_PORT_RESET = 16'd5000;
   localparam logic [7:0]  TSN_PRIORITY_RESET = 8'd3;

   // Everything the classifier needs to know about one completed frame.
   typedef struct packed {
      logic [LEN_WIDTH-1:0] length;
      logic                 is_vlan;
      logic                 is_ipv4;
      logic [3:0]           header_words;
      logic [7:0]           ip_protocol;
      logic [15:0]          udp_dest_port;
      logic [7:0]           frame_prio;
   } frame_summary_type;

   typedef struct packed {
      logic              valid;
      frame_summary_type summary;
   } summary_push_type;

endpackage

### rtl/etpc_front.sv
// Byte parser for the egress TSN packet classifier.
// Tracks the byte position, captures header fields and emits a frame summary on
// the last byte. Depends on etpc_pkg.
module etpc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_accept,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_first_byte,
   input  logic                      req_last_byte,
   input  logic [7:0]                req_priority_in,
   output etpc_pkg::summary_push_type push
);

   logic [etpc_pkg::POS_WIDTH-1:0] pos_ff;
   logic [etpc_pkg::POS_WIDTH-1:0] pos_in;
   logic [15:0]                    outer_ethertype_ff;
   logic [15:0]                    outer_ethertype_in;
   logic [15:0]                    inner_ethertype_ff;
   logic [15:0]                    inner_ethertype_in;
   logic [3:0]                     header_words_ff;
   logic [3:0]                     header_words_in;
   logic [7:0]                     ip_protocol_ff;
   logic [7:0]                     ip_protocol_in;
   logic [15:0]                    udp_dest_port_ff;
   logic [15:0]                    udp_dest_port_in;
   logic [7:0]                     frame_prio_ff;
   logic [7:0]                     frame_prio_in;

   logic [etpc_pkg::POS_WIDTH-1:0] pos;
   logic                           is_vlan;
   logic [etpc_pkg::POS_WIDTH-1:0] l3_pos;
   logic [etpc_pkg::POS_WIDTH-1:0] udp_pos;

   always_comb begin
      pos = req_first_byte ? '0 : pos_ff;

      // A new frame starts with cleared fields and a fresh priority sample.
      if (pos == '0) begin
         outer_ethertype_in = '0;
         inner_ethertype_in = '0;
         header_words_in    = '0;
         ip_protocol_in     = '0;
         udp_dest_port_in   = '0;
         frame_prio_in      = req_priority_in;
      end else begin
         outer_ethertype_in = outer_ethertype_ff;
         inner_ethertype_in = inner_ethertype_ff;
         header_words_in    = header_words_ff;
         ip_protocol_in     = ip_protocol_ff;
         udp_dest_port_in   = udp_dest_port_ff;
         frame_prio_in      = frame_prio_ff;
      end

      if (pos == etpc_pkg::POS_OUTER_HI) outer_ethertype_in[15:8] = req_data_byte;
      if (pos == etpc_pkg::POS_OUTER_LO) outer_ethertype_in[7:0]  = req_data_byte;

      is_vlan = (outer_ethertype_in == etpc_pkg::ETYPE_VLAN_Q) ||
                (outer_ethertype_in == etpc_pkg::ETYPE_VLAN_AD);

      if (is_vlan) begin
         if (pos == etpc_pkg::POS_VLAN_TCI) frame_prio_in = {5'd0, req_data_byte[7:5]};
         if (pos == etpc_pkg::POS_INNER_HI) inner_ethertype_in[15:8] = req_data_byte;
         if (pos == etpc_pkg::POS_INNER_LO) inner_ethertype_in[7:0]  = req_data_byte;
         l3_pos = etpc_pkg::POS_WIDTH'(etpc_pkg::VLAN_L3_LEN);
      end else begin
         l3_pos = etpc_pkg::POS_WIDTH'(etpc_pkg::ETH_HDR_LEN);
      end

      udp_pos = l3_pos + {1'b0, header_words_in, 2'b00};
      if (pos >= etpc_pkg::POS_WIDTH'(etpc_pkg::ETH_HDR_LEN)) begin
         if (pos == l3_pos) header_words_in = req_data_byte[3:0];
         if (pos == l3_pos + etpc_pkg::IP_PROTO_OFFSET) ip_protocol_in = req_data_byte;
         // The UDP offset follows the IHL as it stands after this byte.
         udp_pos = l3_pos + {1'b0, header_words_in, 2'b00};
         if (pos == udp_pos + etpc_pkg::UDP_DPORT_HI_OFFS) begin
            udp_dest_port_in[15:8] = req_data_byte;
         end
         if (pos == udp_pos + etpc_pkg::UDP_DPORT_LO_OFFS) begin
            udp_dest_port_in[7:0] = req_data_byte;
         end
      end

      if (req_last_byte) begin
         pos_in = '0;
      end else if (pos < etpc_pkg::POS_MAX) begin
         pos_in = pos + 1'b1;
      end else begin
         pos_in = etpc_pkg::POS_MAX;
      end
   end

   always_comb begin
      push.valid                 = in_accept && req_last_byte;
      push.summary.length        = {1'b0, pos} + 1'b1;
      push.summary.is_vlan       = is_vlan;
      push.summary.is_ipv4       = is_vlan ? (inner_ethertype_in == etpc_pkg::ETYPE_IPV4)
                                           : (outer_ethertype_in == etpc_pkg::ETYPE_IPV4);
      push.summary.header_words  = header_words_in;
      push.summary.ip_protocol   = ip_protocol_in;
      push.summary.udp_dest_port = udp_dest_port_in;
      push.summary.frame_prio    = frame_prio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (in_accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         outer_ethertype_ff <= outer_ethertype_in;
         inner_ethertype_ff <= inner_ethertype_in;
         header_words_ff    <= header_words_in;
         ip_protocol_ff     <= ip_protocol_in;
         udp_dest_port_ff   <= udp_dest_port_in;
         frame_prio_ff      <= frame_prio_in;
      end
   end

endmodule

### rtl/etpc_queue.sv
// Short summary queue between the parser and the classifier.
// A small register FIFO of frame summaries. Depends on etpc_pkg.
module etpc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  etpc_pkg::summary_push_type  push,
   input  logic                        pop,
   output logic                        full,
   output logic                        empty,
   output etpc_pkg::frame_summary_type head
);

   localparam int PTR_WIDTH = (etpc_pkg::QUEUE_DEPTH > 1) ? $clog2(etpc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(etpc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(etpc_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(etpc_pkg::QUEUE_DEPTH);

   etpc_pkg::frame_summary_type entries_ff [etpc_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.summary;
      end
   end

endmodule

### rtl/etpc_back.sv
// Frame classifier and counters for the egress TSN packet classifier.
// Takes frame summaries from the queue, applies the verdict rules, updates the
// wrapping counters and holds the result register. Depends on etpc_pkg.
module etpc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [etpc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   input  logic                        queue_empty,
   input  etpc_pkg::frame_summary_type queue_head,
   output logic                        queue_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_verdict,
   output logic [1:0]                  rsp_traffic_class,
   output logic [7:0]                  rsp_effective_priority,
   output logic [etpc_pkg::OUT_COUNT_WIDTH-1:0] rsp_total_count,
   output logic [etpc_pkg::OUT_COUNT_WIDTH-1:0] rsp_tsn_count,
   output logic [etpc_pkg::OUT_COUNT_WIDTH-1:0] rsp_best_effort_count
);

   logic [15:0] tsn_udp_port_ff;
   logic [7:0]  tsn_priority_ff;

   logic [etpc_pkg::COUNT_WIDTH-1:0] total_ff;
   logic [etpc_pkg::COUNT_WIDTH-1:0] total_in;
   logic [etpc_pkg::COUNT_WIDTH-1:0] tsn_ff;
   logic [etpc_pkg::COUNT_WIDTH-1:0] tsn_in;
   logic [etpc_pkg::COUNT_WIDTH-1:0] best_effort_ff;
   logic [etpc_pkg::COUNT_WIDTH-1:0] best_effort_in;

   logic                              out_valid_ff;
   etpc_pkg::verdict_type             verdict_ff;
   etpc_pkg::traffic_class_type       class_ff;
   logic [7:0]                        prio_ff;

   etpc_pkg::verdict_type             verdict;
   etpc_pkg::traffic_class_type       tclass;
   logic                              counted;
   logic [etpc_pkg::LEN_WIDTH-1:0]    l3_len;
   logic [etpc_pkg::LEN_WIDTH-1:0]    udp_end;

   // Configuration registers; user must write only when no frame is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         tsn_udp_port_ff <= etpc_pkg::TSN_UDP_PORT_RESET;
         tsn_priority_ff <= etpc_pkg::TSN_PRIORITY_RESET;
      end else if (csr_write_enable) begin
         unique case (etpc_pkg::csr_index_type'(csr_index))
            etpc_pkg::CSR_TSN_UDP_PORT: tsn_udp_port_ff <= csr_write_data[15:0];
            etpc_pkg::CSR_TSN_PRIORITY: tsn_priority_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      l3_len  = queue_head.is_vlan ? etpc_pkg::VLAN_L3_LEN : etpc_pkg::ETH_HDR_LEN;
      udp_end = l3_len + {2'b00, queue_head.header_words, 2'b00} + etpc_pkg::UDP_HDR_LEN;
      counted = 1'b0;
      verdict = etpc_pkg::VERDICT_BEST_EFFORT;

      if (queue_head.length < etpc_pkg::ETH_HDR_LEN) begin
         verdict = etpc_pkg::VERDICT_SHORT;
      end else begin
         counted = 1'b1;
         if (queue_head.is_vlan && (queue_head.length < etpc_pkg::VLAN_L3_LEN)) begin
            verdict = etpc_pkg::VERDICT_TOTAL_ONLY;
         end else if (!queue_head.is_ipv4) begin
            verdict = etpc_pkg::VERDICT_BEST_EFFORT;
         end else if (queue_head.length < l3_len + etpc_pkg::IP_MIN_LEN) begin
            verdict = etpc_pkg::VERDICT_TOTAL_ONLY;
         end else if (queue_head.header_words < etpc_pkg::IHL_MIN) begin
            verdict = etpc_pkg::VERDICT_TOTAL_ONLY;
         end else if (queue_head.ip_protocol != etpc_pkg::PROTO_UDP) begin
            verdict = etpc_pkg::VERDICT_BEST_EFFORT;
         end else if (queue_head.length < udp_end) begin
            verdict = etpc_pkg::VERDICT_TOTAL_ONLY;
         end else if ((queue_head.udp_dest_port == tsn_udp_port_ff) ||
                      (queue_head.frame_prio == tsn_priority_ff)) begin
            verdict = etpc_pkg::VERDICT_TSN;
         end else begin
            verdict = etpc_pkg::VERDICT_BEST_EFFORT;
         end
      end

      if (queue_head.frame_prio == etpc_pkg::PRIO_HIGH) begin
         tclass = etpc_pkg::CLASS_HIGH;
      end else if (queue_head.frame_prio == etpc_pkg::PRIO_MEDIUM) begin
         tclass = etpc_pkg::CLASS_MEDIUM;
      end else begin
         tclass = etpc_pkg::CLASS_LOW;
      end

      total_in       = total_ff + etpc_pkg::COUNT_WIDTH'(counted);
      tsn_in         = tsn_ff + etpc_pkg::COUNT_WIDTH'(verdict == etpc_pkg::VERDICT_TSN);
      best_effort_in = best_effort_ff +
                       etpc_pkg::COUNT_WIDTH'(verdict == etpc_pkg::VERDICT_BEST_EFFORT);
   end

   // The result register frees as the current result is taken.
   assign queue_pop = !queue_empty && (!out_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         total_ff       <= '0;
         tsn_ff         <= '0;
         best_effort_ff <= '0;
      end else begin
         if (queue_pop) begin
            out_valid_ff   <= 1'b1;
            total_ff       <= total_in;
            tsn_ff         <= tsn_in;
            best_effort_ff <= best_effort_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         verdict_ff <= verdict;
         class_ff   <= tclass;
         prio_ff    <= queue_head.frame_prio;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_verdict            = verdict_ff;
   assign rsp_traffic_class      = class_ff;
   assign rsp_effective_priority = prio_ff;
   assign rsp_total_count        = etpc_pkg::OUT_COUNT_WIDTH'(total_ff);
   assign rsp_tsn_count          = etpc_pkg::OUT_COUNT_WIDTH'(tsn_ff);
   assign rsp_best_effort_count  = etpc_pkg::OUT_COUNT_WIDTH'(best_effort_ff);

endmodule

### rtl/egress_tsn_packet_classifier_top.sv
// Top level of the egress TSN packet classifier: parser, summary queue and classifier.
// Depends on etpc_pkg, etpc_front, etpc_queue and etpc_back.
// Throughput is one frame byte per cycle while the summary queue is not full and one result
// per cycle while the result side does not stall; the byte parser handles every byte in the cycle it is accepted.
// A result passes from its last byte into the summary queue and from there into the result
// register. Reset clears the byte position, queue and counters and loads the
// register defaults (UDP port 5000, priority 3); there is no clearing pass.
module egress_tsn_packet_classifier_top (
   input  logic        clock,
   input  logic        reset,

   // Configuration write port.
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,

   // Frame bytes in.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [7:0]  req_priority_in,

   // Per-frame results out.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [1:0]  rsp_traffic_class,
   output logic [7:0]  rsp_effective_priority,
   output logic [31:0] rsp_total_count,
   output logic [31:0] rsp_tsn_count,
   output logic [31:0] rsp_best_effort_count
);

   etpc_pkg::summary_push_type  push;
   etpc_pkg::frame_summary_type queue_head;
   logic                        queue_full;
   logic                        queue_empty;
   logic                        queue_pop;
   logic                        in_accept;

   // The input is held off only when the summary queue is full. Since the
   // queue is popped whenever the result register is free or being emptied,
   // this happens only while the result side stalls, so a frame byte is
   // taken every cycle in normal operation.
   assign req_stall = queue_full;
   assign in_accept = req_valid && !req_stall;

   // The parser sees every accepted transaction and pushes one summary per
   // frame, on its last byte.
   etpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (in_accept),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .req_priority_in (req_priority_in),
      .push            (push)
   );

   // The queue decouples the parser from the classifier, so a stalled result
   // does not stop the byte stream at once.
   etpc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (queue_pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (queue_head)
   );

   // The classifier applies the verdict rules, updates the counters and
   // presents each result transaction from its output register.
   etpc_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .queue_empty            (queue_empty),
      .queue_head             (queue_head),
      .queue_pop              (queue_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_verdict            (rsp_verdict),
      .rsp_traffic_class      (rsp_traffic_class),
      .rsp_effective_priority (rsp_effective_priority),
      .rsp_total_count        (rsp_total_count),
      .rsp_tsn_count          (rsp_tsn_count),
      .rsp_best_effort_count  (rsp_best_effort_count)
   );

endmodule
